// File: hdl/cas_pkg.sv
`timescale 1ns / 1ps
package cas_pkg;

	localparam int MAX_COLS   = 64;
	localparam int ROW_W      = 64;
	localparam int COL_CNT_W  = 7;
	localparam int THRESH_W   = 4;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MIN   = 2'd2;

	localparam logic [COL_CNT_W-1:0] COL_COUNT_RST   = 7'd64;
	localparam logic [THRESH_W-1:0]  SURVIVE_MIN_RST = 4'd4;
	localparam logic [THRESH_W-1:0]  BIRTH_MIN_RST   = 4'd5;

	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_ONE,
		HELD_TWO
	} cas_held_t;

	typedef struct packed {
		logic [ROW_W-1:0] above;
		logic [ROW_W-1:0] mid;
		logic [ROW_W-1:0] below;
		logic             done;
	} cas_job_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             done;
	} cas_res_t;

	function automatic logic [ROW_W-1:0] col_mask(input logic [COL_CNT_W-1:0] n);
		logic [ROW_W-1:0] m;
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = (COL_CNT_W'(j) < n);
		end
		return m;
	endfunction

endpackage

// File: hdl/cas_row_window.sv
`timescale 1ns / 1ps
module cas_row_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       drain,
	input  logic [cas_pkg::ROW_W-1:0]  row,
	input  logic                       last,
	input  logic [cas_pkg::ROW_W-1:0]  mask,
	output cas_pkg::cas_job_t          job_a_s1,
	output cas_pkg::cas_job_t          job_b_s1,
	output logic                       va_s1,
	output logic                       vb_s1
);
	import cas_pkg::*;

	localparam logic [ROW_W-1:0] ALL_WALL = '1;

	cas_held_t        held_q, held_d;
	logic [ROW_W-1:0] upper_q, upper_d;
	logic [ROW_W-1:0] middle_q, middle_d;
	logic [ROW_W-1:0] rowf;
	cas_job_t         job_a_d, job_b_d;
	logic             va_d, vb_d;

	always_comb begin
		rowf     = (row & mask) | ~mask;
		held_d   = held_q;
		upper_d  = upper_q;
		middle_d = middle_q;
		job_a_d  = job_a_s1;
		job_b_d  = job_b_s1;
		va_d     = va_s1 & ~drain;
		vb_d     = vb_s1 & ~drain;
		if (take) begin
			va_d = 1'b0;
			vb_d = 1'b0;
			case (held_q)
				HELD_NONE: begin
					if (last) begin
						job_a_d = '{above: ALL_WALL, mid: rowf, below: ALL_WALL, done: 1'b1};
						va_d    = 1'b1;
						upper_d  = '0;
						middle_d = '0;
					end else begin
						middle_d = rowf;
						held_d   = HELD_ONE;
					end
				end
				HELD_ONE, HELD_TWO: begin
					job_a_d = '{above: (held_q == HELD_ONE) ? ALL_WALL : upper_q,
						mid: middle_q, below: rowf, done: 1'b0};
					va_d    = 1'b1;
					if (last) begin
						job_b_d = '{above: middle_q, mid: rowf, below: ALL_WALL, done: 1'b1};
						vb_d     = 1'b1;
						upper_d  = '0;
						middle_d = '0;
						held_d   = HELD_NONE;
					end else begin
						upper_d  = middle_q;
						middle_d = rowf;
						held_d   = HELD_TWO;
					end
				end
				default: begin
					held_d = HELD_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
			va_s1  <= 1'b0;
			vb_s1  <= 1'b0;
		end else begin
			held_q <= held_d;
			va_s1  <= va_d;
			vb_s1  <= vb_d;
		end
	end

	always_ff @(posedge clk) begin
		upper_q  <= upper_d;
		middle_q <= middle_d;
		job_a_s1 <= job_a_d;
		job_b_s1 <= job_b_d;
	end

endmodule

// File: hdl/cas_smooth.sv
`timescale 1ns / 1ps
module cas_smooth (
	input  cas_pkg::cas_job_t              job,
	input  logic [cas_pkg::ROW_W-1:0]      mask,
	input  logic [cas_pkg::THRESH_W-1:0]   survive_min,
	input  logic [cas_pkg::THRESH_W-1:0]   birth_min,
	output logic [cas_pkg::ROW_W-1:0]      new_row
);
	import cas_pkg::*;

	logic [ROW_W-1:0]    m;
	logic [ROW_W-1:0]    planes [8];
	logic [ROW_W-1:0]    upd;
	logic [THRESH_W-1:0] cnt [ROW_W];

	always_comb begin
		m         = (job.mid & mask) | ~mask;
		planes[0] = {job.above[ROW_W-2:0], 1'b1};
		planes[1] = job.above;
		planes[2] = {1'b1, job.above[ROW_W-1:1]};
		planes[3] = {m[ROW_W-2:0], 1'b1};
		planes[4] = {1'b1, m[ROW_W-1:1]};
		planes[5] = {job.below[ROW_W-2:0], 1'b1};
		planes[6] = job.below;
		planes[7] = {1'b1, job.below[ROW_W-1:1]};
		for (int j = 0; j < ROW_W; j++) begin
			cnt[j] = '0;
			for (int k = 0; k < 8; k++) begin
				cnt[j] = cnt[j] + THRESH_W'(planes[k][j]);
			end
			upd[j] = m[j] ? (cnt[j] >= survive_min) : (cnt[j] >= birth_min);
		end
		new_row = upd & mask;
	end

endmodule

// File: hdl/cas_out_fifo.sv
`timescale 1ns / 1ps
module cas_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push_a,
	input  logic                          push_b,
	input  cas_pkg::cas_res_t             din_a,
	input  cas_pkg::cas_res_t             din_b,
	input  logic                          pop,
	output logic                          valid,
	output cas_pkg::cas_res_t             dout,
	output logic [cas_pkg::FIFO_CNT_W-1:0] space
);
	import cas_pkg::*;

	cas_res_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic [FIFO_PTR_W-1:0] wr_next;

	assign wr_next = wr_q + FIFO_PTR_W'(1);
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign space   = FIFO_CNT_W'(FIFO_DEPTH) - cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
			rd_q  <= rd_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
				- FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= din_a;
		end
		if (push_b) begin
			mem_q[wr_next] <= din_b;
		end
	end

endmodule

// File: hdl/cave_automaton_row_smoother_top.sv
`timescale 1ns / 1ps
// Path: input window register, then result queue. Throughput: one row word per
// cycle in while the queue has room, one result word per cycle out on m_tready;
// a final row after earlier rows yields two results, so the output queue sets the
// pace right after a grid ends.
// Reset: asynchronous, clears the row window, queue and valid bits; registers
// return to col_count 64, survive_min 4, birth_min 5.
module cave_automaton_row_smoother_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cas_pkg::ROW_W-1:0]         s_tdata,   // row_cells[63:0]
	input  logic                              s_tlast,   // final_row
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cas_pkg::ROW_W-1:0]         m_tdata,   // new_row[63:0]
	output logic                              m_tlast,   // grid_done
	input  logic                              cfg_we,
	input  logic [cas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cas_pkg::*;

	logic [COL_CNT_W-1:0]  col_count_q;
	logic [THRESH_W-1:0]   survive_min_q;
	logic [THRESH_W-1:0]   birth_min_q;
	logic [ROW_W-1:0]      mask;
	cas_job_t              job_a_s1, job_b_s1;
	logic                  va_s1, vb_s1;
	logic                  take, drain, fits, pop;
	logic [FIFO_CNT_W-1:0] space;
	logic [FIFO_CNT_W-1:0] need;
	cas_res_t              res_a, res_b, res_out;
	logic                  out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q   <= COL_COUNT_RST;
			survive_min_q <= SURVIVE_MIN_RST;
			birth_min_q   <= BIRTH_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COL_COUNT:   col_count_q   <= cfg_data;
				CFG_SURVIVE_MIN: survive_min_q <= cfg_data[THRESH_W-1:0];
				CFG_BIRTH_MIN:   birth_min_q   <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign mask     = col_mask(col_count_q);
	assign pop      = out_valid & m_tready;
	assign need     = FIFO_CNT_W'(va_s1) + FIFO_CNT_W'(vb_s1);
	assign fits     = (space + FIFO_CNT_W'(pop)) >= need;
	assign drain    = (va_s1 | vb_s1) & fits;
	assign s_tready = ~(va_s1 | vb_s1) | drain;
	assign take     = s_tvalid & s_tready;

	cas_row_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.drain    (drain),
		.row      (s_tdata),
		.last     (s_tlast),
		.mask     (mask),
		.job_a_s1 (job_a_s1),
		.job_b_s1 (job_b_s1),
		.va_s1    (va_s1),
		.vb_s1    (vb_s1)
	);

	cas_smooth u_smooth_a (
		.job         (job_a_s1),
		.mask        (mask),
		.survive_min (survive_min_q),
		.birth_min   (birth_min_q),
		.new_row     (res_a.row)
	);
	assign res_a.done = job_a_s1.done;

	cas_smooth u_smooth_b (
		.job         (job_b_s1),
		.mask        (mask),
		.survive_min (survive_min_q),
		.birth_min   (birth_min_q),
		.new_row     (res_b.row)
	);
	assign res_b.done = job_b_s1.done;

	cas_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (drain & va_s1),
		.push_b (drain & vb_s1),
		.din_a  (res_a),
		.din_b  (res_b),
		.pop    (pop),
		.valid  (out_valid),
		.dout   (res_out),
		.space  (space)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = res_out.row;
	assign m_tlast  = res_out.done;

`ifndef SYNTHESIS
	a_b_needs_a: assert property (@(posedge clk) disable iff (!arst_n)
		vb_s1 |-> va_s1)
		else $error("second result without first");

	a_b_is_grid_end: assert property (@(posedge clk) disable iff (!arst_n)
		vb_s1 |-> (job_b_s1.done && !job_a_s1.done))
		else $error("bad grid end marking on result pair");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (va_s1 || vb_s1))
		else $error("input stalled with empty window stage");

	a_space_bound: assert property (@(posedge clk) disable iff (!arst_n)
		space <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");
`endif

endmodule
